/* hw/rtl/assert_macros.svh */
// Assertion macros for the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define DQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/dqd_pkg.sv */
// Opcodes, status codes and port widths for the deque.
package dqd_pkg;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int IO_W     = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DELETE     = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

endpackage

/* hw/rtl/deque_with_delete_by_value_core.sv */
// Pushes and unused opcodes: result registered at the accepting edge, busy stays low.
// Pops: the store read is registered at the accepting edge, then S_POP registers the result;
// a pop on an empty deque answers at the accepting edge. Delete: one entry per cycle
// through the single store read port, scanning then closing the gap.
// Reset clears head, count and the sequencer; stored words are not cleared.
// Results are strobed for one cycle on done_o; one item in flight, the receiver cannot stall.
module deque_with_delete_by_value_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [dqd_pkg::OP_W-1:0]        opcode_i,
  input  logic signed [dqd_pkg::IO_W-1:0] data_in_i,
  output logic                            done_o,
  output logic signed [dqd_pkg::IO_W-1:0] data_out_o,
  output logic [CW-1:0]                   count_out_o,
  output logic [dqd_pkg::STATUS_W-1:0]    status_o
);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  dqd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .opcode_i    (opcode_i),
    .data_in_i   (data_in_i),
    .busy_o      (busy),
    .done_o      (done_o),
    .data_out_o  (data_out_o),
    .count_out_o (count_out_o),
    .status_o    (status_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  dqd_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* hw/rtl/dqd_mem.sv */
// Entry store: one write port, one read port with registered read data.
module dqd_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/dqd_ctrl.sv */
// Sequencer, shared slot adder and comparator, ring pointers and result register.
`include "assert_macros.svh"

module dqd_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dqd_pkg::OP_W-1:0]       opcode_i,
  input  logic signed [dqd_pkg::IO_W-1:0] data_in_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic signed [dqd_pkg::IO_W-1:0] data_out_o,
  output logic [CW-1:0]                  count_out_o,
  output logic [dqd_pkg::STATUS_W-1:0]   status_o,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [DATA_WIDTH-1:0]          mem_wdata_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]          mem_rdata_i
);
  import dqd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            head_q, head_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            pos_q, pos_d;
  logic [CW-1:0]            wpos_q, wpos_d;
  logic [AW-1:0]            wslot_q, wslot_d;
  logic [DATA_WIDTH-1:0]    key_q, key_d;
  logic                     cmp_vld_q, cmp_vld_d;
  logic [CW-1:0]            cmp_pos_q, cmp_pos_d;
  logic [AW-1:0]            cmp_slot_q, cmp_slot_d;
  logic                     done_q, done_d;
  logic signed [IO_W-1:0]   dout_q, dout_d;
  status_e                  status_q, status_d;

  opcode_e                  op;
  logic [DATA_WIDTH-1:0]    word_in;
  logic [CW-1:0]            idle_pos;
  logic [CW-1:0]            pos_in;
  logic [AW:0]              slot_sum;
  logic [AW-1:0]            slot;
  logic [AW-1:0]            head_inc;
  logic                     full;
  logic                     empty;
  logic                     match;
  logic                     issue;

  assign op       = opcode_e'(opcode_i);
  assign word_in  = DATA_WIDTH'($unsigned(data_in_i));
  assign full     = (cnt_q == CW'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign match    = cmp_vld_q && (mem_rdata_i == key_q);

  always_comb begin
    case (op)
      OP_PUSH_BACK:  idle_pos = cnt_q;
      OP_POP_BACK:   idle_pos = cnt_q - CW'(1);
      OP_PUSH_FRONT: idle_pos = CW'(DEPTH - 1);
      default:       idle_pos = '0;
    endcase
  end

  // Shared slot adder: head plus position, wrapped once into the ring.
  assign pos_in   = (state_q == S_IDLE) ? idle_pos : pos_q;
  assign slot_sum = {1'b0, head_q} + (AW + 1)'(pos_in);
  assign slot     = (slot_sum >= (AW + 1)'(DEPTH)) ?
                    AW'(slot_sum - (AW + 1)'(DEPTH)) : slot_sum[AW-1:0];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    wpos_d      = wpos_q;
    wslot_d     = wslot_q;
    key_d       = key_q;
    done_d      = 1'b0;
    dout_d      = '0;
    status_d    = status_q;
    issue       = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot;
    mem_wdata_o = word_in;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (op)
            OP_PUSH_BACK: begin
              done_d = 1'b1;
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                cnt_d    = cnt_q + CW'(1);
                status_d = ST_OK;
              end
            end
            OP_PUSH_FRONT: begin
              done_d = 1'b1;
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                head_d   = slot;
                cnt_d    = cnt_q + CW'(1);
                status_d = ST_OK;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                cnt_d   = cnt_q - CW'(1);
                state_d = S_POP;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                head_d  = head_inc;
                cnt_d   = cnt_q - CW'(1);
                state_d = S_POP;
              end
            end
            OP_DELETE: begin
              key_d = word_in;
              if (empty) begin
                done_d   = 1'b1;
                status_d = ST_NOMATCH;
              end else begin
                issue   = 1'b1;
                pos_d   = CW'(1);
                state_d = S_SCAN;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        done_d   = 1'b1;
        dout_d   = $signed(IO_W'(mem_rdata_i));
        status_d = ST_OK;
        state_d  = S_IDLE;
      end
      S_SCAN: begin
        // Read one entry a cycle; compare the one read the cycle before.
        issue = (pos_q < cnt_q);
        if (issue) begin
          pos_d = pos_q + CW'(1);
        end
        if (match) begin
          wpos_d  = cmp_pos_q;
          wslot_d = cmp_slot_q;
          state_d = S_SHIFT;
        end else if (cmp_vld_q && (cmp_pos_q == cnt_q - CW'(1))) begin
          done_d   = 1'b1;
          status_d = ST_NOMATCH;
          state_d  = S_IDLE;
        end
      end
      S_SHIFT: begin
        issue = (pos_q < cnt_q);
        if (issue) begin
          pos_d = pos_q + CW'(1);
        end
        // Move the next entry up into the gap, one place a cycle.
        if ((wpos_q + CW'(1)) < cnt_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wslot_q;
          mem_wdata_o = mem_rdata_i;
          wslot_d     = cmp_slot_q;
          wpos_d      = wpos_q + CW'(1);
        end else begin
          cnt_d    = cnt_q - CW'(1);
          done_d   = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmp_vld_d  = issue;
  assign cmp_pos_d  = pos_in;
  assign cmp_slot_d = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      cnt_q      <= '0;
      pos_q      <= '0;
      wpos_q     <= '0;
      wslot_q    <= '0;
      key_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_pos_q  <= '0;
      cmp_slot_q <= '0;
      done_q     <= 1'b0;
      dout_q     <= '0;
      status_q   <= ST_OK;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      pos_q      <= pos_d;
      wpos_q     <= wpos_d;
      wslot_q    <= wslot_d;
      key_q      <= key_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_pos_q  <= cmp_pos_d;
      cmp_slot_q <= cmp_slot_d;
      done_q     <= done_d;
      dout_q     <= dout_d;
      status_q   <= status_d;
    end
  end

  assign mem_raddr_o = slot;
  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign data_out_o  = dout_q;
  assign count_out_o = cnt_q;
  assign status_o    = status_q;

  `DQD_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "entry count above depth")
  `DQD_ASSERT(a_head_bound, head_q <= AW'(DEPTH - 1), "head index outside ring")
  `DQD_ASSERT_NEXT(a_accept_resp, start_i && !busy_o, done_q || busy_o, "accepted beat lost")
  `DQD_ASSERT(a_shift_pos, state_q != S_SHIFT || wpos_q < cnt_q, "shift past last entry")

endmodule
